FILE: design/sh3_pkg.sv
// Shared constants, register indexes and the sharpen kernel function.
package sh3_pkg;

    // Sizes fixed by the register map and the sample format
    localparam int SAMPLE_W     = 8;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CHAN_REG_W   = 3;
    localparam int ROW_W        = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    // Parameter defaults
    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_CHANNELS = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    // Register reset values
    localparam logic [WIDTH_REG_W-1:0]  RST_FRAME_WIDTH   = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] RST_FRAME_HEIGHT  = 13'd480;
    localparam logic [CHAN_REG_W-1:0]   RST_CHANNEL_COUNT = 3'd3;

    // Working bounds
    localparam int MIN_WIDTH  = 3;
    localparam int MIN_HEIGHT = 3;
    localparam int MAX_HEIGHT = 4096;

    // 5*center minus four neighbors, clamped to 0..255
    function automatic logic [SAMPLE_W-1:0] sharpen(
        input logic [SAMPLE_W-1:0] c,
        input logic [SAMPLE_W-1:0] t,
        input logic [SAMPLE_W-1:0] b,
        input logic [SAMPLE_W-1:0] l,
        input logic [SAMPLE_W-1:0] r
    );
        logic [10:0]        pos;
        logic [9:0]         neg;
        logic signed [11:0] s;
        logic [SAMPLE_W-1:0] res;
        pos = {1'b0, c, 2'b00} + 11'(c);
        neg = 10'(t) + 10'(b) + 10'(l) + 10'(r);
        s   = $signed({1'b0, pos}) - $signed({2'b00, neg});
        if (s < 12'sd0) begin
            res = '0;
        end else if (s > 12'sd255) begin
            res = '1;
        end else begin
            res = s[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: design/sh3_line_buf.sv
// Two line stores (upper and middle rows) with registered reads and write forwarding.
module sh3_line_buf #(
    parameter int DEPTH = sh3_pkg::DEF_MAX_WIDTH * sh3_pkg::DEF_MAX_CHANNELS
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]      i_addr,
    input  logic [sh3_pkg::SAMPLE_W-1:0]  i_bot,
    input  logic                          i_up_we,
    input  logic [$clog2(DEPTH)-1:0]      i_up_addr,
    input  logic [sh3_pkg::SAMPLE_W-1:0]  i_up_data,
    output logic [sh3_pkg::SAMPLE_W-1:0]  o_top,
    output logic [sh3_pkg::SAMPLE_W-1:0]  o_mid
);

    logic [sh3_pkg::SAMPLE_W-1:0] r_upper [DEPTH];
    logic [sh3_pkg::SAMPLE_W-1:0] r_middle [DEPTH];
    logic [sh3_pkg::SAMPLE_W-1:0] r_top_q;
    logic [sh3_pkg::SAMPLE_W-1:0] r_byp_data;
    logic                         r_byp;

    // Middle row: read old value, store the incoming sample at the same entry
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_middle[i_addr] <= i_bot;
            o_mid            <= r_middle[i_addr];
        end
    end

    // Upper row: written later through its own port with the middle value read before
    always_ff @(posedge i_clk) begin
        if (i_up_we) begin
            r_upper[i_up_addr] <= i_up_data;
        end
        if (i_rd_en) begin
            r_top_q <= r_upper[i_addr];
        end
    end

    // Forward a same-edge upper write to the read that collides with it
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp      <= i_up_we && (i_up_addr == i_addr);
            r_byp_data <= i_up_data;
        end
    end

    assign o_top = r_byp ? r_byp_data : r_top_q;

endmodule

FILE: design/sharpen_3x3_stream.sv
// Top level of the 3x3 cross sharpen filter on an interleaved sample stream.
//
//  Channel   Direction  Signals                         Payload
//  --------  ---------  ------------------------------  ---------------------------------
//  s_axis    in         tvalid, tready, tdata[7:0]      sample_in
//  m_axis    out        tvalid, tready, tdata[7:0],     sharp_sample; tlast = frame_done
//                       tlast
//  cfg       in         i_cfg_we, i_cfg_idx, i_cfg_data 0 width, 1 height, 2 channels
//
// One sample is taken per clock unless a stalled m_axis holds stage 1. A result
// passes through the registered line-store read into stage 1, then through the
// kernel and clamp into the output register. Synchronous active-low reset clears the
// counters, the valid flags and the registers to 640 x 480 x 3. When m_axis
// stalls, the output register holds, and so does stage 1 while it carries an
// interior result; input is still taken while stage 1 is empty or able to move on.
module sharpen_3x3_stream #(
    parameter int MAX_WIDTH    = sh3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = sh3_pkg::DEF_MAX_CHANNELS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // sample input
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [7:0] sample_in
    // sharpened output
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,   // [7:0] sharp_sample
    output logic                             m_axis_tlast,   // frame_done
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [sh3_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sh3_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int CHW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int WCMP_W = (CW >= sh3_pkg::WIDTH_REG_W) ? CW + 1 : sh3_pkg::WIDTH_REG_W + 1;
    localparam int PW     = CW + 3;
    localparam int SW     = sh3_pkg::SAMPLE_W;
    localparam int HW     = sh3_pkg::HEIGHT_REG_W;
    localparam int NW     = sh3_pkg::CHAN_REG_W;

    // Configuration registers
    logic [sh3_pkg::WIDTH_REG_W-1:0] r_frame_width;
    logic [HW-1:0]                   r_frame_height;
    logic [NW-1:0]                   r_channel_count;

    // Position counters
    logic [CW-1:0]               r_col;
    logic [sh3_pkg::ROW_W-1:0]   r_row;
    logic [CHW-1:0]              r_chan;

    // Stage 1: item waiting for its line-store read data
    logic            r_s1_valid;
    logic            r_s1_prod;
    logic            r_s1_last;
    logic [CHW-1:0]  r_s1_ch;
    logic [AW-1:0]   r_s1_addr;
    logic [SW-1:0]   r_s1_bot;

    // Window taps per channel: column x-1 of three rows and x-2 of the middle row
    logic [SW-1:0] r_top1 [MAX_CHANNELS];
    logic [SW-1:0] r_mid1 [MAX_CHANNELS];
    logic [SW-1:0] r_bot1 [MAX_CHANNELS];
    logic [SW-1:0] r_mid2 [MAX_CHANNELS];

    // Output register
    logic          r_o_valid;
    logic [SW-1:0] r_o_data;
    logic          r_o_last;

    logic [WCMP_W-1:0] w_eff;
    logic [HW-1:0]     h_eff;
    logic [NW-1:0]     nc_eff;
    logic              in_xfer;
    logic              s1_go;
    logic [CHW:0]      ch_inc;
    logic [WCMP_W-1:0] col_inc;
    logic [HW-1:0]     row_inc;
    logic              ch_wrap;
    logic              col_wrap;
    logic              row_wrap;
    logic              n_prod;
    logic              n_last;
    logic [PW-1:0]     p_full;
    logic [AW-1:0]     rd_addr;
    logic [SW-1:0]     lb_top;
    logic [SW-1:0]     lb_mid;
    logic [SW-1:0]     kern_out;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= sh3_pkg::RST_FRAME_WIDTH;
            r_frame_height  <= sh3_pkg::RST_FRAME_HEIGHT;
            r_channel_count <= sh3_pkg::RST_CHANNEL_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sh3_pkg::REG_FRAME_WIDTH:
                    r_frame_width <= i_cfg_data[sh3_pkg::WIDTH_REG_W-1:0];
                sh3_pkg::REG_FRAME_HEIGHT:
                    r_frame_height <= i_cfg_data[HW-1:0];
                sh3_pkg::REG_CHANNEL_COUNT:
                    r_channel_count <= i_cfg_data[NW-1:0];
                default: ;
            endcase
        end
    end

    // Saturate the registers to the working ranges
    always_comb begin
        w_eff = WCMP_W'(r_frame_width);
        if (w_eff < WCMP_W'(sh3_pkg::MIN_WIDTH)) begin
            w_eff = WCMP_W'(sh3_pkg::MIN_WIDTH);
        end else if (w_eff > WCMP_W'(MAX_WIDTH)) begin
            w_eff = WCMP_W'(MAX_WIDTH);
        end

        h_eff = r_frame_height;
        if (h_eff < HW'(sh3_pkg::MIN_HEIGHT)) begin
            h_eff = HW'(sh3_pkg::MIN_HEIGHT);
        end else if (h_eff > HW'(sh3_pkg::MAX_HEIGHT)) begin
            h_eff = HW'(sh3_pkg::MAX_HEIGHT);
        end

        nc_eff = r_channel_count;
        if (nc_eff < NW'(1)) begin
            nc_eff = NW'(1);
        end else if (nc_eff > NW'(MAX_CHANNELS)) begin
            nc_eff = NW'(MAX_CHANNELS);
        end
    end

    // Handshakes: stage 1 moves on when it has no result or the output can take one
    assign s1_go         = r_s1_valid && (!r_s1_prod || !r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_go;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Position bookkeeping for the incoming sample
    assign ch_inc   = {1'b0, r_chan} + (CHW+1)'(1);
    assign col_inc  = WCMP_W'(r_col) + WCMP_W'(1);
    assign row_inc  = HW'(r_row) + HW'(1);
    assign ch_wrap  = NW'(ch_inc) >= nc_eff;
    assign col_wrap = col_inc >= w_eff;
    assign row_wrap = row_inc >= h_eff;
    assign n_prod   = (r_row >= sh3_pkg::ROW_W'(2)) && (r_col >= CW'(2));
    assign n_last   = row_wrap && col_wrap && ch_wrap;
    assign p_full   = PW'(r_col) * PW'(nc_eff) + PW'(r_chan);
    assign rd_addr  = p_full[AW-1:0];

    // Advance channel, then column, then row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0;
            r_col  <= '0;
            r_row  <= '0;
        end else if (in_xfer) begin
            if (ch_wrap) begin
                r_chan <= '0;
                if (col_wrap) begin
                    r_col <= '0;
                    r_row <= row_wrap ? '0 : row_inc[sh3_pkg::ROW_W-1:0];
                end else begin
                    r_col <= col_inc[CW-1:0];
                end
            end else begin
                r_chan <= ch_inc[CHW-1:0];
            end
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_prod <= n_prod;
            r_s1_last <= n_last;
            r_s1_ch   <= r_chan;
            r_s1_addr <= rd_addr;
            r_s1_bot  <= s_axis_tdata;
        end
    end

    // Upper row takes the old middle value once it has been read
    sh3_line_buf #(
        .DEPTH (DEPTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (in_xfer),
        .i_addr    (rd_addr),
        .i_bot     (s_axis_tdata),
        .i_up_we   (s1_go),
        .i_up_addr (r_s1_addr),
        .i_up_data (lb_mid),
        .o_top     (lb_top),
        .o_mid     (lb_mid)
    );

    // Kernel: center x-1 of the middle row, right neighbor is the fresh middle read
    assign kern_out = sh3_pkg::sharpen(r_mid1[r_s1_ch], r_top1[r_s1_ch], r_bot1[r_s1_ch],
                                       r_mid2[r_s1_ch], lb_mid);

    // Shift the window of this channel by one column
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_mid2[r_s1_ch] <= r_mid1[r_s1_ch];
            r_top1[r_s1_ch] <= lb_top;
            r_mid1[r_s1_ch] <= lb_mid;
            r_bot1[r_s1_ch] <= r_s1_bot;
        end
    end

    // Output register: load on an interior result, drop after its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_go && r_s1_prod) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_prod) begin
            r_o_data <= kern_out;
            r_o_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;

    // The last sample of a frame returns every counter to zero
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && n_last) |=> (r_row == '0 && r_col == '0 && r_chan == '0))
        else $error("counters not cleared after last sample of frame");

    // The frame flag only rides on an interior result
    a_last_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |-> r_s1_prod)
        else $error("frame flag on a border sample");

    // An interior result leaving stage 1 shows up on the output next cycle
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_prod) |=> m_axis_tvalid)
        else $error("interior result lost between stage 1 and output");

endmodule
